FILE: design/peak_window_weighted_centroid_defines.svh
// Assertion macros for the peak window centroid checker.
`ifndef PEAK_WINDOW_WEIGHTED_CENTROID_DEFINES_SVH
`define PEAK_WINDOW_WEIGHTED_CENTROID_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PWWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pwwc check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define PWWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pwwc check failed");

`endif

FILE: design/pwwc_pkg.sv
// Package: types, constants and register codes of the peak window centroid block.
package pwwc_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int SCORE_W     = 24;
    localparam int POS_W       = 24;
    localparam int WIN_W       = 10;
    localparam int RATIO_W     = 8;
    localparam int WEIGHT_W    = 31;
    localparam int DIV_STEPS   = 24;

    localparam logic [WIN_W-1:0]          WINDOW_RESET = 10'd100;
    localparam logic [RATIO_W-1:0]        RATIO_RESET  = 8'd230;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN    = 24'sh800000;

    // Register index, decoded from paddr[2].
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_RATIO  = 1'b1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [POS_W-1:0]          position;
        logic                      last;
    } t_in_beat;

    typedef struct packed {
        logic [POS_W-1:0]          centroid;
        logic signed [SCORE_W-1:0] peak_score;
        logic                      valid_res;
        logic                      overflowed;
    } t_out_beat;

    typedef struct packed {
        logic [WIN_W-1:0]   window_half;
        logic [RATIO_W-1:0] threshold_ratio;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic setup;
        logic walk;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic walk_end;
        logic pipe_idle;
        logic div_last;
    } t_sts;

endpackage

FILE: design/pwwc_regs.sv
// APB configuration registers: window half width and threshold ratio.
module pwwc_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output pwwc_pkg::t_cfg      o_cfg
);

    logic [pwwc_pkg::WIN_W-1:0]   r_window;
    logic [pwwc_pkg::RATIO_W-1:0] r_ratio;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= pwwc_pkg::WINDOW_RESET;
            r_ratio  <= pwwc_pkg::RATIO_RESET;
        end else if (wr_en) begin
            if (paddr[2] == pwwc_pkg::REG_WINDOW) begin
                r_window <= pwdata[pwwc_pkg::WIN_W-1:0];
            end else begin
                r_ratio <= pwdata[pwwc_pkg::RATIO_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == pwwc_pkg::REG_WINDOW) begin
            prdata = {{(32 - pwwc_pkg::WIN_W){1'b0}}, r_window};
        end else begin
            prdata = {{(32 - pwwc_pkg::RATIO_W){1'b0}}, r_ratio};
        end
    end

    assign o_cfg.window_half     = r_window;
    assign o_cfg.threshold_ratio = r_ratio;

endmodule

FILE: design/pwwc_ctrl.sv
// Controller: load, setup, window walk, drain, divide and result hand-off sequencing.
module pwwc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pwwc_pkg::t_cmd o_cmd,
    input  pwwc_pkg::t_sts i_sts
);

    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_SETUP  = 6'b000010,
        S_WALK   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_idle) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/pwwc_dp.sv
// Datapath: sample memory, peak tracking, weighting pipeline, accumulators, divider.
module pwwc_dp #(
    parameter int MAX_SAMPLES = pwwc_pkg::MAX_SAMPLES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pwwc_pkg::t_cfg       i_cfg,
    input  pwwc_pkg::t_in_beat   i_in_data,
    input  pwwc_pkg::t_cmd       i_cmd,
    output pwwc_pkg::t_sts       o_sts,
    output pwwc_pkg::t_out_beat  o_out_data
);

    localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW  = AW + 1;
    localparam int XW  = ((CW > pwwc_pkg::WIN_W) ? CW : pwwc_pkg::WIN_W) + 1;
    localparam int SW_ = pwwc_pkg::SCORE_W;
    localparam int PW  = pwwc_pkg::POS_W;
    localparam int WW  = pwwc_pkg::WEIGHT_W + AW;
    localparam int MW  = pwwc_pkg::WEIGHT_W + PW;
    localparam int SPW = WW + PW;
    localparam int DW  = $clog2(pwwc_pkg::DIV_STEPS);

    logic [SW_+PW-1:0] mem [MAX_SAMPLES];

    // set state
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_peak_idx;
    logic signed [SW_-1:0] r_peak_val;
    logic [PW-1:0]         r_peak_pos;
    logic                  r_ovf;
    logic                  full;

    // walk
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_hi;
    logic signed [32:0]    r_thr;
    logic signed [32:0]    thr_full;
    logic [XW-1:0]         peak_x;
    logic [XW-1:0]         win_x;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         sum_x;
    logic [XW-1:0]         lo_x;
    logic [XW-1:0]         hi_x;
    logic                  rd_en;

    // pipeline
    logic                  r_v1, r_v2, r_v3;
    logic [SW_+PW-1:0]     r_rd;
    logic signed [SW_-1:0] rd_score;
    logic signed [32:0]    sc;
    logic signed [33:0]    diff;
    logic                  qual;
    logic [pwwc_pkg::WEIGHT_W-1:0] r_w;
    logic [pwwc_pkg::WEIGHT_W-1:0] r_w3;
    logic [PW-1:0]         r_p2;
    logic [MW-1:0]         r_prod;
    logic [MW-1:0]         prod_full;
    logic [WW-1:0]         r_sw;
    logic [SPW-1:0]        r_sp;

    // divider
    logic [WW-1:0]         r_rem;
    logic [PW-1:0]         r_dvd;
    logic [PW-1:0]         r_q;
    logic [DW-1:0]         r_dcnt;
    logic [WW:0]           trial;
    logic                  ge;
    logic [WW-1:0]         n_rem;

    logic                  res_valid;
    pwwc_pkg::t_out_beat   r_out;

    assign full = (r_count == CW'(MAX_SAMPLES));

    // window bounds
    assign peak_x = XW'(r_peak_idx);
    assign win_x  = XW'(i_cfg.window_half);
    assign cnt_x  = XW'(r_count);
    assign sum_x  = peak_x + win_x;
    assign lo_x   = (peak_x > win_x) ? (peak_x - win_x) : '0;
    assign hi_x   = (sum_x < cnt_x) ? sum_x : cnt_x;
    assign thr_full = r_peak_val * $signed({1'b0, i_cfg.threshold_ratio});

    assign o_sts.walk_end  = !(r_idx < r_hi);
    assign o_sts.pipe_idle = !(r_v1 || r_v2 || r_v3);
    assign o_sts.div_last  = (r_dcnt == DW'(pwwc_pkg::DIV_STEPS - 1));

    assign rd_en = i_cmd.walk && !o_sts.walk_end;

    // memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem[r_count[AW-1:0]] <= {i_in_data.score, i_in_data.position};
        end
        if (rd_en) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    // set state and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_peak_idx <= '0;
            r_peak_val <= pwwc_pkg::SCORE_MIN;
            r_ovf      <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                    if (i_in_data.score > r_peak_val) begin
                        r_peak_val <= i_in_data.score;
                        r_peak_idx <= r_count[AW-1:0];
                    end
                end
            end else if (i_cmd.finish) begin
                r_count    <= '0;
                r_peak_idx <= '0;
                r_peak_val <= pwwc_pkg::SCORE_MIN;
                r_ovf      <= 1'b0;
            end
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // weighting
    assign rd_score  = r_rd[SW_+PW-1:PW];
    assign sc        = $signed({rd_score[SW_-1], rd_score, 8'b0});
    assign diff      = $signed({sc[32], sc}) - $signed({r_thr[32], r_thr});
    assign qual      = !diff[33] && (diff != '0);
    assign prod_full = MW'(r_w) * MW'(r_p2);

    // divider step
    assign trial = {r_rem, r_dvd[PW-1]};
    assign ge    = (trial >= {1'b0, r_sw});
    assign n_rem = ge ? WW'(trial - {1'b0, r_sw}) : trial[WW-1:0];

    assign res_valid = (r_sw != '0);

    always_ff @(posedge i_clk) begin
        // first beat of a set is the peak until a strictly higher score arrives
        if (i_cmd.load && !full &&
            ((i_in_data.score > r_peak_val) || (r_count == '0))) begin
            r_peak_pos <= i_in_data.position;
        end
        if (i_cmd.setup) begin
            r_idx <= lo_x[CW-1:0];
            r_hi  <= hi_x[CW-1:0];
            r_thr <= thr_full;
            r_sw  <= '0;
            r_sp  <= '0;
        end else begin
            if (rd_en) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_v3) begin
                r_sw <= r_sw + WW'(r_w3);
                r_sp <= r_sp + SPW'(r_prod);
            end
        end
        r_w    <= qual ? diff[pwwc_pkg::WEIGHT_W-1:0] : '0;
        r_p2   <= r_rd[PW-1:0];
        r_prod <= prod_full;
        r_w3   <= r_w;
        if (i_cmd.div_start) begin
            r_rem  <= r_sp[SPW-1:PW];
            r_dvd  <= r_sp[PW-1:0];
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_dvd  <= {r_dvd[PW-2:0], 1'b0};
            r_q    <= {r_q[PW-2:0], ge};
            r_dcnt <= r_dcnt + DW'(1);
        end
        if (i_cmd.finish) begin
            r_out.centroid   <= res_valid ? r_q : r_peak_pos;
            r_out.peak_score <= r_peak_val;
            r_out.valid_res  <= res_valid;
            r_out.overflowed <= r_ovf;
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: design/peak_window_weighted_centroid.sv
// Top level: weighted centroid of samples around the peak of a loaded set.
//
//   port group    dir   handshake          payload
//   in            in    i_in_valid/o_in_stall   t_in_beat  (score, position, last)
//   out           out   o_out_valid/i_out_stall t_out_beat (centroid, peak_score, flags)
//   config        in    APB psel/penable        window_half @0, threshold_ratio @4
//
// Samples load one beat per cycle into the sample memory while o_in_stall is low.
// After a last beat: a setup step, a walk over the memory read port, a drain of the
// weighting pipeline, the divider steps and a hand-off; input stalls meanwhile.
// Output register lets loading of the next set start while a result waits.
// Reset is synchronous; sample memory is not cleared.
module peak_window_weighted_centroid #(
    parameter int MAX_SAMPLES = pwwc_pkg::MAX_SAMPLES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pwwc_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pwwc_pkg::t_out_beat  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    pwwc_pkg::t_cfg cfg;
    pwwc_pkg::t_cmd cmd;
    pwwc_pkg::t_sts sts;

    pwwc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pwwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pwwc_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

FILE: design/pwwc_chk.sv
// Port-level checker for the peak window centroid block, with its bind.
`include "peak_window_weighted_centroid_defines.svh"

module pwwc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input pwwc_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pwwc_pkg::t_out_beat o_out_data
);

    `PWWC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    `PWWC_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))

    `PWWC_ASSERT_NEXT(a_last_stalls, i_in_valid && !o_in_stall && i_in_data.last, o_in_stall)

    `PWWC_ASSERT_NOW(a_valid_pos_peak, o_out_valid && o_out_data.valid_res, $signed(o_out_data.peak_score) > 24'sd0)

endmodule

bind peak_window_weighted_centroid pwwc_chk u_pwwc_chk (.*);
